### rtl/art_pkg.sv
// ---------------------------------------------------------------------------
// art_pkg
// Shared types, codes and sizes for the ack retransmit table.
// ---------------------------------------------------------------------------
package art_pkg;

    localparam int unsigned LIST_DEPTH_DEF = 16;
    localparam int unsigned CMDQ_DEPTH     = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ACK    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_RESEND    = 3'd0,
        KIND_GAVE_UP   = 3'd1,
        KIND_ACK_MATCH = 3'd2,
        KIND_ACK_MISS  = 3'd3,
        KIND_INSERTED  = 3'd4,
        KIND_FULL      = 3'd5,
        KIND_TICK_DONE = 3'd6
    } kind_t;

    typedef enum logic {
        REG_TIMER_RELOAD  = 1'b0,
        REG_RESEND_BUDGET = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] node_addr;
        logic [6:0]  dimming;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] node_addr_res;
        logic [6:0]  dimming_res;
        logic [4:0]  pending;
        logic        last;
    } out_item_t;

    // front to back command
    typedef struct packed {
        op_t         op;
        logic [15:0] node_addr;
        logic [6:0]  dimming;
    } cmd_t;

endpackage

### rtl/art_front.sv
// ---------------------------------------------------------------------------
// art_front
// Accepts input beats, drops unused opcodes, queues commands for the back end.
// ---------------------------------------------------------------------------
module art_front
    import art_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_item,
    input  logic     push,
    output logic     full,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_take
);
    cmd_t       q_reg [CMDQ_DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr;

    assign full      = (cnt_reg == 2'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign wr        = push && !full && (op_t'(in_item.opcode) != OP_NONE);

    always_comb
    begin
        wp_next  = wr ? ~wp_reg : wp_reg;
        rp_next  = (cmd_take && cmd_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(wr) - 2'(cmd_take && cmd_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= '{op: op_t'(in_item.opcode), node_addr: in_item.node_addr,
                               dimming: in_item.dimming};
        end
    end
endmodule

### rtl/art_back.sv
// ---------------------------------------------------------------------------
// art_back
// Entry list and sequencer: insert, ack search, tick sweep; one entry a cycle, may stall.
// ---------------------------------------------------------------------------
module art_back
    import art_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_take,
    output out_item_t res,
    output logic      empty,
    input  logic      pop
);
    localparam int unsigned IW = $clog2(LIST_DEPTH);
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    logic [15:0] dev_reg [LIST_DEPTH];
    logic [6:0]  dim_reg [LIST_DEPTH];
    logic [7:0]  tmr_reg [LIST_DEPTH];
    logic [3:0]  bud_reg [LIST_DEPTH];

    logic [7:0]  reload_reg;
    logic [3:0]  budget_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    state_t      state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic        done_reg, done_next;   // after SHIFT, go to DONE (ack) or SCAN (tick)

    out_item_t   res_reg, res_next;
    logic        full_reg, full_next;

    logic [IW-1:0] ix, ixp;
    logic          wr_ins, wr_upd, wr_shift;
    logic          emit;

    assign ix    = idx_reg[IW-1:0];
    assign ixp   = IW'(idx_reg + CW'(1));
    assign empty = !full_reg;
    assign res   = res_reg;

    function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
        return 5'(c);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        done_next  = done_reg;
        res_next   = res_reg;
        full_next  = full_reg;
        cmd_take   = 1'b0;
        wr_ins     = 1'b0;
        wr_upd     = 1'b0;
        wr_shift   = 1'b0;
        emit       = 1'b0;
        if (pop && full_reg)
            full_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cur_next   = cmd;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                    if (cmd.op == OP_INSERT)
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg >= count_reg)
                    state_next = ST_DONE;
                else if (cur_reg.op == OP_ACK)
                begin
                    if (dev_reg[ix] == cur_reg.node_addr && dim_reg[ix] == cur_reg.dimming)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
                else if (!full_next)
                begin
                    if (bud_reg[ix] == 4'd0)
                    begin
                        emit      = 1'b1;
                        res_next  = '{kind: KIND_GAVE_UP, node_addr_res: dev_reg[ix],
                                      dimming_res: dim_reg[ix],
                                      pending: cnt5(count_reg - CW'(1)), last: 1'b0};
                        done_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        wr_upd = 1'b1;
                        if (tmr_reg[ix] == 8'd0)
                        begin
                            emit     = 1'b1;
                            res_next = '{kind: KIND_RESEND, node_addr_res: dev_reg[ix],
                                         dimming_res: dim_reg[ix],
                                         pending: cnt5(count_reg), last: 1'b0};
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            ST_SHIFT:
            begin
                // move entry idx+1 down into idx until end of list
                if (idx_reg + CW'(1) < count_reg)
                begin
                    wr_shift = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (done_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_SCAN;
                        idx_next   = cur_reg.node_addr[CW-1:0];  // restore scan position
                    end
                end
            end
            ST_DONE:
            begin
                if (!full_next)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b0;
                    case (cur_reg.op)
                        OP_INSERT:
                        begin
                            if (count_reg >= CW'(LIST_DEPTH))
                                res_next = '{kind: KIND_FULL,
                                             node_addr_res: cur_reg.node_addr,
                                             dimming_res: cur_reg.dimming,
                                             pending: cnt5(count_reg), last: 1'b1};
                            else
                            begin
                                wr_ins     = 1'b1;
                                count_next = count_reg + CW'(1);
                                res_next   = '{kind: KIND_INSERTED,
                                               node_addr_res: cur_reg.node_addr,
                                               dimming_res: cur_reg.dimming,
                                               pending: cnt5(count_reg + CW'(1)),
                                               last: 1'b1};
                            end
                        end
                        OP_ACK:
                            res_next = '{kind: done_reg ? KIND_ACK_MATCH : KIND_ACK_MISS,
                                         node_addr_res: cur_reg.node_addr,
                                         dimming_res: cur_reg.dimming,
                                         pending: cnt5(count_reg), last: 1'b1};
                        default:
                            res_next = '{kind: KIND_TICK_DONE, node_addr_res: 16'd0,
                                         dimming_res: 7'd0, pending: cnt5(count_reg),
                                         last: 1'b1};
                    endcase
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (emit)
            full_next = 1'b1;
        // gave-up during tick: remember scan index in the spare address field
        if (state_reg == ST_SCAN && state_next == ST_SHIFT && cur_reg.op == OP_TICK)
            cur_next.node_addr = 16'(idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            full_reg   <= 1'b0;
            reload_reg <= 8'd5;
            budget_reg <= 4'd3;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            full_reg  <= full_next;
            if (cfg_we && reg_idx_t'(cfg_index) == REG_TIMER_RELOAD)
                reload_reg <= cfg_data;
            if (cfg_we && reg_idx_t'(cfg_index) == REG_RESEND_BUDGET)
                budget_reg <= cfg_data[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (wr_ins)
        begin
            dev_reg[count_reg[IW-1:0]] <= cur_reg.node_addr;
            dim_reg[count_reg[IW-1:0]] <= cur_reg.dimming;
            tmr_reg[count_reg[IW-1:0]] <= reload_reg;
            bud_reg[count_reg[IW-1:0]] <= budget_reg;
        end
        if (wr_upd)
        begin
            if (tmr_reg[ix] == 8'd0)
            begin
                tmr_reg[ix] <= reload_reg;
                bud_reg[ix] <= bud_reg[ix] - 4'd1;
            end
            else
                tmr_reg[ix] <= tmr_reg[ix] - 8'd1;
        end
        if (wr_shift)
        begin
            dev_reg[ix] <= dev_reg[ixp];
            dim_reg[ix] <= dim_reg[ixp];
            tmr_reg[ix] <= tmr_reg[ixp];
            bud_reg[ix] <= bud_reg[ixp];
        end
    end
endmodule

### rtl/ack_retransmit_table.sv
// ---------------------------------------------------------------------------
// ack_retransmit_table
// Retransmission timer table with queue-style input and result ports.
// ---------------------------------------------------------------------------
// An insert is answered without a list walk. An ack search visits one
// entry a cycle whether it hits or misses, and on a hit the newer entries
// are moved down one a cycle. A tick walks the list one entry a cycle while
// the result register is free; for each entry that is given up, the newer
// entries are shifted down before the walk resumes. The single result
// register sets the pace when the consumer stalls: the sweep waits until
// the previous beat is popped. A two-deep command queue lets new beats be
// pushed while a sweep runs. Opcode 3 is swallowed with no result.
// Config writes: index 0 reload, index 1 resend budget; write only while idle.
module ack_retransmit_table
    import art_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      push,
    output logic      full,
    output out_item_t out_item,
    output logic      empty,
    input  logic      pop,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);
    cmd_t cmd;
    logic cmd_valid, cmd_take;

    art_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    art_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .res(out_item), .empty(empty), .pop(pop)
    );
endmodule

### rtl/art_checker.sv
// ---------------------------------------------------------------------------
// art_props
// Port-level checks on the ack retransmit table.
// ---------------------------------------------------------------------------
module art_props
    import art_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.kind <= KIND_TICK_DONE))
        else $error("bad kind");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.kind == KIND_RESEND || out_item.kind == KIND_GAVE_UP))
        |-> !out_item.last)
        else $error("sweep beat marked last");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.kind == KIND_TICK_DONE) |-> (out_item.node_addr_res == 16'd0))
        else $error("tick done carries device");
endmodule

bind ack_retransmit_table art_props u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_item(out_item)
);
